// File: sv/dpe_pkg.sv
// Shared types, constants and tables for the 2D decay profile evaluator.
package dpe_pkg;

   localparam logic [1:0] MODE_CAUCHY  = 2'd0;
   localparam logic [1:0] MODE_GAUSS   = 2'd1;
   localparam logic [1:0] MODE_MIX     = 2'd2;
   localparam logic [1:0] MODE_MIX_ALT = 2'd3;  // behaves as the mix

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_LX   = 2'd1;
   localparam logic [1:0] REG_LY   = 2'd2;
   localparam logic [1:0] REG_ETA  = 2'd3;

   localparam logic [15:0] HALF_LOG2E = 16'd47274;
   localparam logic [15:0] TWO_PI_Q13 = 16'd51472;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] lx;
      logic [15:0] ly;
      logic [16:0] eta;
   } cfg_type;

   function automatic logic [16:0] exp2_tab(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0: v = 17'd65536;  5'd1: v = 17'd62758;  5'd2: v = 17'd60097;
         5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
         5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
         5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
         5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
         5'd15: v = 17'd34219; 5'd16: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] log2_tab(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0: v = 17'd0;      5'd1: v = 17'd5732;   5'd2: v = 17'd11136;
         5'd3: v = 17'd16248;  5'd4: v = 17'd21098;  5'd5: v = 17'd25711;
         5'd6: v = 17'd30109;  5'd7: v = 17'd34312;  5'd8: v = 17'd38336;
         5'd9: v = 17'd42196;  5'd10: v = 17'd45904; 5'd11: v = 17'd49472;
         5'd12: v = 17'd52911; 5'd13: v = 17'd56229; 5'd14: v = 17'd59434;
         5'd15: v = 17'd62534; 5'd16: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // 2^-y: y has 16 fraction bits, integer part given separately (saturated).
   // Interpolated table value, before the shift.
   function automatic logic [16:0] exp2_interp(input logic [15:0] f);
      logic [16:0] a, b;
      logic [28:0] p;
      a = exp2_tab({1'b0, f[15:12]});
      b = exp2_tab({1'b0, f[15:12]} + 5'd1);
      p = 29'(a - b) * 29'(f[11:0]);
      return a - 17'(p >> 12);
   endfunction

   function automatic logic [16:0] exp2_shift(input logic [16:0] v, input logic [5:0] n);
      logic [17:0] r;
      if (n > 6'd16) return 17'd0;
      if (n == 6'd0) return v;
      r = (18'(v) + (18'd1 << (n - 6'd1))) >> n;
      return r[16:0];
   endfunction

endpackage

// File: sv/decay_profile_2d_eval.sv
// Top level of the 2D decay profile evaluator: registers, pipeline, handshake.
// Pipeline: 7 register stages from the req transfer to rsp_valid.
// Throughput: one point per cycle; the whole pipeline stalls when the
// output stage holds an untaken result.
// Reset: synchronous; clears all valid bits and loads the register defaults
// (Cauchy mode, both lengths 1.0 nm, eta 0).
module decay_profile_2d_eval (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_q_x,
   input  logic [15:0] req_q_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_profile_value,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_write_data
);
   dpe_pkg::cfg_type cfg_ff, cfg_in;
   logic             adv, fv, sv;
   logic [62:0]      s;
   logic [16:0]      shp;

   // stall everything while the last stage holds an untaken result
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dpe_pkg::REG_MODE: cfg_in.mode = csr_write_data[1:0];
            dpe_pkg::REG_LX:   cfg_in.lx   = csr_write_data[15:0];
            dpe_pkg::REG_LY:   cfg_in.ly   = csr_write_data[15:0];
            dpe_pkg::REG_ETA:  cfg_in.eta  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: dpe_pkg::MODE_CAUCHY, lx: 16'd256, ly: 16'd256, eta: 17'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpe_front u_front (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid),
      .q_x(req_q_x), .q_y(req_q_y), .cfg(cfg_ff), .out_valid(fv), .s_out(s)
   );

   dpe_shape u_shape (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(fv), .s_in(s),
      .cfg(cfg_ff), .out_valid(sv), .shape_out(shp)
   );

   dpe_scale u_scale (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(sv), .shape(shp),
      .cfg(cfg_ff), .out_valid(rsp_valid), .value(rsp_profile_value)
   );
endmodule

// File: sv/dpe_front.sv
// Front stages: magnitudes, scaled lengths and the squared radius s.
module dpe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [15:0]       q_x,
   input  logic [15:0]       q_y,
   input  dpe_pkg::cfg_type  cfg,
   output logic              out_valid,
   output logic [62:0]       s_out
);
   logic              v1_ff, v2_ff, v1_in, v2_in;
   logic [30:0]       tx_ff, ty_ff, tx_in, ty_in;
   logic [62:0]       s_ff, s_in;
   logic [16:0]       mx, my;
   logic [32:0]       px, py;

   // magnitude and length product, saturated
   always_comb begin
      mx = q_x[15] ? 17'h10000 - {1'b0, q_x} : 17'(q_x);
      my = q_y[15] ? 17'h10000 - {1'b0, q_y} : 17'(q_y);
      px = 33'(mx) * 33'(cfg.lx);
      py = 33'(my) * 33'(cfg.ly);
      tx_in = (px > 33'h7FFFFFFF) ? 31'h7FFFFFFF : px[30:0];
      ty_in = (py > 33'h7FFFFFFF) ? 31'h7FFFFFFF : py[30:0];
      s_in = 63'(tx_ff) * 63'(tx_ff) + 63'(ty_ff) * 63'(ty_ff);
      v1_in = adv ? in_valid : v1_ff;
      v2_in = adv ? v1_ff : v2_ff;
   end

   // advance payload on enable
   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         s_ff  <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   assign out_valid = v2_ff;
   assign s_out = s_ff;
endmodule

// File: sv/dpe_shape.sv
// Shape stages: log2 of 1+s, exponent forming, 2^-y and the mix.
module dpe_shape (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [62:0]       s_in,
   input  dpe_pkg::cfg_type  cfg,
   output logic              out_valid,
   output logic [16:0]       shape_out
);
   logic        v1_ff, v2_ff, v3_ff, v1_in, v2_in, v3_in;
   logic [21:0] lg_ff, lg_in;       // log2(1+s) in Q.16
   logic [21:0] yg_ff, yg_in;       // Gauss exponent
   logic [16:0] g_ff, c_ff, g_in, c_in;
   logic [5:0]  ng_ff, nc_ff, ng_in, nc_in;
   logic [16:0] sh_ff, sh_in;
   logic [63:0] u;
   logic [4:0]  p;
   logic [15:0] frac;
   logic [16:0] la, lb;
   logic [28:0] lp;
   logic [54:0] gy;
   logic [22:0] yc;
   logic [16:0] eta;
   logic [33:0] mixsum;

   // stage 1: leading one of u and log2 interpolation; Gauss exponent
   always_comb begin
      u = 64'(s_in) + (64'd1 << 40);
      p = 5'd0;
      for (int i = 1; i < 24; i++) begin
         if (u[40 + i]) p = 5'(i);
      end
      frac = 16'((u << (6'd23 - 6'(p))) >> 47);
      la = dpe_pkg::log2_tab({1'b0, frac[15:12]});
      lb = dpe_pkg::log2_tab({1'b0, frac[15:12]} + 5'd1);
      lp = 29'(lb - la) * 29'(frac[11:0]);
      lg_in = 22'({p, 16'd0}) + 22'(la) + 22'(lp >> 12);
      gy = 55'(s_in >> 24) * 55'(dpe_pkg::HALF_LOG2E);
      yg_in = (gy[54:16] > 39'h3FFFFF) ? 22'h3FFFFF : gy[37:16];
      v1_in = adv ? in_valid : v1_ff;
   end

   // stage 2: Cauchy exponent and both 2^-y interpolations
   always_comb begin
      yc = (23'(lg_ff) * 23'd3) >> 1;
      g_in = dpe_pkg::exp2_interp(yg_ff[15:0]);
      c_in = dpe_pkg::exp2_interp(yc[15:0]);
      ng_in = 6'(yg_ff[21:16]);
      nc_in = (yc[22:16] > 7'd63) ? 6'd63 : 6'(yc[22:16]);
      v2_in = adv ? v1_ff : v2_ff;
   end

   // stage 3: shift, mix and mode select
   always_comb begin
      logic [16:0] gs, cs;
      gs = dpe_pkg::exp2_shift(g_ff, ng_ff);
      cs = dpe_pkg::exp2_shift(c_ff, nc_ff);
      eta = (cfg.eta > 17'd65536) ? 17'd65536 : cfg.eta;
      mixsum = 34'(eta) * 34'(gs) + 34'(17'd65536 - eta) * 34'(cs) + 34'd32768;
      if (cfg.mode == dpe_pkg::MODE_CAUCHY) sh_in = cs;
      else if (cfg.mode == dpe_pkg::MODE_GAUSS) sh_in = gs;
      else sh_in = mixsum[32:16];
      v3_in = adv ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lg_ff <= lg_in;
         yg_ff <= yg_in;
         g_ff  <= g_in;
         c_ff  <= c_in;
         ng_ff <= ng_in;
         nc_ff <= nc_in;
         sh_ff <= sh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign out_valid = v3_ff;
   assign shape_out = sh_ff;

`ifndef SYNTH
   a_shape_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> sh_ff <= 17'd65536) else $error("shape above one");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sh_ff)) else $error("shape moved in stall");
   a_gauss_zero: assert property (@(posedge clock) disable iff (reset)
      (adv && s_in == 63'd0) |=> yg_ff == 22'd0) else $error("gauss exp nonzero");
`endif
endmodule

// File: sv/dpe_scale.sv
// Back stages: prefactor multiply, 2*pi scale, rounding and clamp.
module dpe_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [16:0]       shape,
   input  dpe_pkg::cfg_type  cfg,
   output logic              out_valid,
   output logic [31:0]       value
);
   logic        v1_ff, v2_ff, v1_in, v2_in;
   logic [48:0] w_ff, w_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] lxy_ff, lxy_in;
   logic [65:0] prod;
   logic [32:0] res;

   always_comb begin
      lxy_in = 32'(cfg.lx) * 32'(cfg.ly);
      // lx*ly*shape fits 49 bits; split 32x17
      w_in = 49'(lxy_ff) * 49'(shape);
      prod = 66'(w_ff) * 66'(dpe_pkg::TWO_PI_Q13) + (66'd1 << 32);
      res = prod[65:33];
      r_in = res[32] ? 32'hFFFFFFFF : res[31:0];
      v1_in = adv ? in_valid : v1_ff;
      v2_in = adv ? v1_ff : v2_ff;
   end

   // lx*ly register; user must change registers only with pipe empty, unenforced
   always_ff @(posedge clock) begin
      lxy_ff <= lxy_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= w_in;
         r_ff <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   assign out_valid = v2_ff;
   assign value = r_ff;
endmodule

// File: verif/profile_checker.sv
// Checker for the 2D decay profile evaluator: watches transfers, predicts and compares.
module profile_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_q_x,
   input  logic [15:0] req_q_y,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_profile_value,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_write_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] T_LIMIT = 64'h7FFF_FFFF;

   // Interpolation tables, Q.16
   localparam logic [16:0] POW2_NEG [0:16] = '{
      17'd65536, 17'd62758, 17'd60097, 17'd57549, 17'd55109, 17'd52773, 17'd50535,
      17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693, 17'd38968, 17'd37316,
      17'd35734, 17'd34219, 17'd32768};
   localparam logic [16:0] LOG2_FRAC [0:16] = '{
      17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
      17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911, 17'd56229,
      17'd59434, 17'd62534, 17'd65536};

   dpe_pkg::cfg_type shadow_cfg;
   logic [31:0]      expected_values[$];

   assign pending_count = expected_values.size();

   // 2^-y, y in Q.16
   function automatic logic [16:0] pow2_neg(input logic [63:0] y);
      logic [63:0] n;
      logic [3:0]  idx;
      logic [11:0] r;
      logic [31:0] v;
      n = y >> 16;
      idx = y[15:12];
      r = y[11:0];
      if (n > 16) return 17'd0;
      v = POW2_NEG[idx] - (((POW2_NEG[idx] - POW2_NEG[idx + 1]) * 32'(r)) >> 12);
      if (n == 0) return v[16:0];
      v = (v + (32'd1 << (n - 1))) >> n;
      return v[16:0];
   endfunction

   function automatic logic [16:0] gauss_decay(input logic [63:0] s);
      return pow2_neg(((s >> 24) * 64'(dpe_pkg::HALF_LOG2E)) >> 16);
   endfunction

   function automatic logic [16:0] cauchy_decay(input logic [63:0] s);
      logic [63:0] u, l2;
      int          p;
      logic [15:0] frac;
      logic [31:0] lg;
      u = s + (64'd1 << 40);
      p = 63;
      while (p > 40 && u[p] == 1'b0) p--;
      frac = 16'(u >> (p - 16));
      lg = LOG2_FRAC[frac[15:12]] + (((LOG2_FRAC[frac[15:12] + 1] - LOG2_FRAC[frac[15:12]])
           * 32'(frac[11:0])) >> 12);
      l2 = (64'(p - 40) << 16) + 64'(lg);
      return pow2_neg((64'd3 * l2) >> 1);
   endfunction

   function automatic logic [63:0] q_abs(input logic [15:0] q);
      return q[15] ? 64'(17'h10000 - 17'(q)) : 64'(q);
   endfunction

   function automatic logic [31:0] predict_profile(input logic [15:0] qx, input logic [15:0] qy);
      logic [63:0] tx, ty, s, eta, g, c, w, res;
      logic [63:0] shape;
      tx = q_abs(qx) * 64'(shadow_cfg.lx);
      ty = q_abs(qy) * 64'(shadow_cfg.ly);
      if (tx > T_LIMIT) tx = T_LIMIT;
      if (ty > T_LIMIT) ty = T_LIMIT;
      s = tx * tx + ty * ty;
      if (shadow_cfg.mode == dpe_pkg::MODE_CAUCHY) begin
         shape = 64'(cauchy_decay(s));
      end else if (shadow_cfg.mode == dpe_pkg::MODE_GAUSS) begin
         shape = 64'(gauss_decay(s));
      end else begin
         // mode three behaves as the mix; eta clamps at one
         eta = shadow_cfg.eta > 17'd65536 ? 64'd65536 : 64'(shadow_cfg.eta);
         g = 64'(gauss_decay(s));
         c = 64'(cauchy_decay(s));
         shape = (eta * g + (64'd65536 - eta) * c + 64'd32768) >> 16;
      end
      w = 64'(shadow_cfg.lx) * 64'(shadow_cfg.ly) * shape;
      res = (w * 64'(dpe_pkg::TWO_PI_Q13) + (64'd1 << 32)) >> 33;
      if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
      return res[31:0];
   endfunction

   // Track registers, predict on request transfer, compare on response transfer
   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg <= '{mode: dpe_pkg::MODE_CAUCHY, lx: 16'd256, ly: 16'd256, eta: 17'd0};
         expected_values.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_values.push_back(predict_profile(req_q_x, req_q_y));
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               $error("profile_value: unexpected transfer, actual %0d", rsp_profile_value);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_profile_value !== expected_values[0]) begin
                  $error("profile_value: expected %0d, actual %0d",
                         expected_values[0], rsp_profile_value);
                  fail_count <= fail_count + 1;
               end
               void'(expected_values.pop_front());
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               dpe_pkg::REG_MODE: shadow_cfg.mode <= csr_write_data[1:0];
               dpe_pkg::REG_LX:   shadow_cfg.lx <= csr_write_data[15:0];
               dpe_pkg::REG_LY:   shadow_cfg.ly <= csr_write_data[15:0];
               dpe_pkg::REG_ETA:  shadow_cfg.eta <= csr_write_data;
               default: ;
            endcase
         end
      end
   end
endmodule

// File: verif/tb.sv
// Testbench top for the 2D decay profile evaluator: stimulus, idling and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_q_x;
   logic [15:0] req_q_y;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_profile_value;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [16:0] csr_write_data;
   int          fail_count;
   int          pending_count;
   int          stall_style;

   decay_profile_2d_eval dut (.*);

   profile_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stall pattern; style changes per phase
   always @(negedge clock) begin
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(3) != 0);
         2: rsp_ready <= ($urandom_range(3) == 0);
         default: rsp_ready <= $urandom_range(1);
      endcase
   end

   task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Drain, then allow pipeline latency before any register change
   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_profile(input logic [1:0] mode, input logic [15:0] lx,
                              input logic [15:0] ly, input logic [16:0] eta);
      wait_drained();
      write_reg(dpe_pkg::REG_MODE, 17'(mode));
      write_reg(dpe_pkg::REG_LX, 17'(lx));
      write_reg(dpe_pkg::REG_LY, 17'(ly));
      write_reg(dpe_pkg::REG_ETA, eta);
   endtask

   // Present one point, hold until the transfer
   task automatic send_point(input logic [15:0] qx, input logic [15:0] qy);
      req_valid <= 1'b1;
      req_q_x <= qx;
      req_q_y <= qy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_burst_points(input int count);
      int left;
      int burst;
      int sel;
      logic [15:0] qx, qy;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && left > 0; k++) begin
            sel = $urandom_range(3);
            // mostly small q so shapes stay non-zero, sometimes full range
            if (sel == 0) begin
               qx = $urandom;
               qy = $urandom;
            end else begin
               qx = 16'($signed(13'($urandom)) >>> (sel - 1));
               qy = 16'($signed(13'($urandom)) >>> (sel - 1));
            end
            send_point(qx, qy);
            left--;
         end
         // drop valid only for a real gap
         if ($urandom_range(2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] corner_q [0:5];
      int waited;
      corner_q = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h1000};
      reset = 1'b1;
      req_valid = 1'b0;
      req_q_x = '0;
      req_q_y = '0;
      stall_style = 0;
      csr_write_enable = 1'b0;
      csr_index = dpe_pkg::REG_MODE;
      csr_write_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes under reset defaults, then each mode
      for (int i = 0; i < 6; i++) send_point(corner_q[i], corner_q[5 - i]);
      req_valid <= 1'b0;
      set_profile(dpe_pkg::MODE_GAUSS, 16'hFFFF, 16'h0001, 17'd0);
      for (int i = 0; i < 5; i++) send_point(corner_q[i], corner_q[i]);
      req_valid <= 1'b0;
      // mix, eta above one
      set_profile(dpe_pkg::MODE_MIX, 16'h0080, 16'h0200, 17'h1FFFF);
      for (int i = 0; i < 5; i++) send_point(corner_q[i], 16'h0100);
      req_valid <= 1'b0;
      // mode three, zero length
      set_profile(dpe_pkg::MODE_MIX_ALT, 16'h0000, 16'h0100, 17'd32768);
      for (int i = 0; i < 4; i++) send_point(16'h0010, corner_q[i]);
      req_valid <= 1'b0;
      set_profile(dpe_pkg::MODE_MIX, 16'hFFFF, 16'hFFFF, 17'd65536);
      send_point(16'h0000, 16'h0000);
      send_point(16'h8000, 16'h7FFF);
      req_valid <= 1'b0;

      // Random phases over several settings
      for (int ph = 0; ph < 12; ph++) begin
         stall_style = ph % 4;
         set_profile(2'($urandom), ($urandom_range(3) == 0) ? 16'($urandom)
                     : 16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                     17'($urandom_range(0, 70000)));
         send_burst_points(80);
      end

      waited = 0;
      while (pending_count != 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
